// ----- rtl/qsv_pkg.sv -----
// ----------------------------------------------------------------------------
// qsv_pkg: shared types and constants of the state vector gate engine
// Store geometry, fixed-point widths, item codes, sequencer states and
// the operand and product types of the shared complex multiplier.
// ----------------------------------------------------------------------------
package qsv_pkg;

  localparam int MAX_QUBITS  = 10;
  localparam int MAX_TARGETS = 3;
  localparam int AMP_WIDTH   = 16;
  localparam int FRAC        = AMP_WIDTH - 2;

  localparam int ADDR_W      = MAX_QUBITS;
  localparam int STORE_DEPTH = 1 << MAX_QUBITS;
  localparam int MAT_DIM     = 1 << MAX_TARGETS;
  localparam int MAT_AW      = 2 * MAX_TARGETS;
  localparam int MAT_DEPTH   = MAT_DIM * MAT_DIM;
  localparam int WORD_W      = 2 * AMP_WIDTH;

  localparam int OPW   = AMP_WIDTH + 1;        // room for a negated minimum
  localparam int PRODW = 2 * OPW + 1;          // sum of two products
  localparam int ACC_W = PRODW + MAX_TARGETS;  // sum over one matrix column
  localparam int CUM_W = PRODW + MAX_QUBITS;   // running probability sum

  localparam int QC_W  = 4;
  localparam logic [QC_W-1:0] QC_RESET = QC_W'(MAX_QUBITS);

  localparam logic [2:0] FN_INIT    = 3'd0;
  localparam logic [2:0] FN_WR_AMP  = 3'd1;
  localparam logic [2:0] FN_WR_MAT  = 3'd2;
  localparam logic [2:0] FN_APPLY   = 3'd3;
  localparam logic [2:0] FN_RD_AMP  = 3'd4;
  localparam logic [2:0] FN_MEASURE = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_G_RD,
    ST_G_CAP,
    ST_X_RD,
    ST_X_ACC,
    ST_WB,
    ST_M_RD,
    ST_M_SQ,
    ST_M_ACC,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic signed [OPW-1:0] re;
    logic signed [OPW-1:0] im;
  } cop_t;

  typedef struct packed {
    logic signed [PRODW-1:0] re;
    logic signed [PRODW-1:0] im;
  } prod_t;

endpackage

// ----- rtl/qsv_if.sv -----
// ----------------------------------------------------------------------------
// qsv_if: channel interfaces of the state vector gate engine
// Item, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface qsv_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [9:0]         position;
  logic [2:0]         column;
  logic signed [15:0] value_re;
  logic signed [15:0] value_im;
  logic [1:0]         target_count;
  logic [3:0]         target_first;
  logic [3:0]         target_second;
  logic [3:0]         target_third;
  logic [15:0]        rand_value;

  modport source (output valid, func, position, column, value_re, value_im,
                  target_count, target_first, target_second, target_third,
                  rand_value, input ready);
  modport sink   (input valid, func, position, column, value_re, value_im,
                  target_count, target_first, target_second, target_third,
                  rand_value, output ready);
endinterface

interface qsv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] amp_re;
  logic signed [15:0] amp_im;
  logic [9:0]         basis_idx;
  logic               status;

  modport source (output valid, amp_re, amp_im, basis_idx, status,
                  input ready);
  modport sink   (input valid, amp_re, amp_im, basis_idx, status,
                  output ready);
endinterface

interface qsv_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/qsv_cmul.sv -----
// ----------------------------------------------------------------------------
// qsv_cmul: shared complex multiplier
// Forms the full-precision complex product a*b of two complex operands.
// ----------------------------------------------------------------------------
module qsv_cmul (
  input  qsv_pkg::cop_t  a,
  input  qsv_pkg::cop_t  b,
  output qsv_pkg::prod_t p
);
  import qsv_pkg::*;

  logic signed [2*OPW-1:0] rr, ii, ri, ir;

  assign rr = a.re * b.re;
  assign ii = a.im * b.im;
  assign ri = a.re * b.im;
  assign ir = a.im * b.re;

  assign p.re = PRODW'(rr) - PRODW'(ii);
  assign p.im = PRODW'(ri) + PRODW'(ir);

endmodule

// ----- rtl/qubit_state_vector_gate_engine.sv -----
// ----------------------------------------------------------------------------
// qubit_state_vector_gate_engine: state vector gate engine
// Amplitude store and gate matrix with one shared complex multiplier
// under a sequencer: init, writes, gate apply, read and measure.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+------------------------------------------------------
//  in_ch    | in  | one item: func, position, column, value, targets, rand
//  out_ch   | out | one result per item: amp_re/im, basis_idx, status
//  cfg_ch   | in  | qubit_count write, taken in any cycle
//
//  Apply reads each group of 2^k amplitudes, then for each output sums 2^k
//  products and writes it back; measure sums |a|^2 in index order until the
//  running sum reaches the threshold or the last index. Item timing is set
//  by the one complex multiplier and the single store read port. After
//  reset a clearing pass writes all 1024 store entries with in_ch not
//  ready. One item is taken at a time; a held result stalls only the end
//  of the next item.
// ----------------------------------------------------------------------------
module qubit_state_vector_gate_engine (
  input logic     clk,
  input logic     rst_n,
  qsv_in_if.sink  in_ch,
  qsv_out_if.source out_ch,
  qsv_cfg_if.sink cfg_ch
);
  import qsv_pkg::*;

  localparam logic signed [AMP_WIDTH-1:0] ONE = AMP_WIDTH'(1 << FRAC);
  localparam int RQ_W = ACC_W + 1 - FRAC;

  function automatic logic [AMP_WIDTH-1:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]  s;
    logic signed [RQ_W-1:0] q;
    logic [AMP_WIDTH-1:0]   r;
    s = $signed({a[ACC_W-1], a}) + $signed((ACC_W + 1)'(1 << (FRAC - 1)));
    q = s[ACC_W:FRAC];
    if (q > $signed(RQ_W'((1 << (AMP_WIDTH - 1)) - 1)))
      r = {1'b0, {(AMP_WIDTH - 1){1'b1}}};
    else if (q < -$signed(RQ_W'(1 << (AMP_WIDTH - 1))))
      r = {1'b1, {(AMP_WIDTH - 1){1'b0}}};
    else
      r = q[AMP_WIDTH-1:0];
    return r;
  endfunction

  st_t state_r, state_nxt;

  // configuration
  logic [QC_W-1:0] qc_r;
  logic [QC_W-1:0] n_eff;
  logic [ADDR_W:0] size;

  // item registers
  logic [2:0]          func_r;
  logic [9:0]          pos_r;
  logic [2:0]          col_r;
  logic [WORD_W-1:0]   val_r;
  logic [1:0]          k_r;
  logic [3:0]          t0_r, t1_r, t2_r;
  logic [15:0]         rand_r;
  logic                init_pend_r;

  // apply control
  logic [ADDR_W-1:0]   oh0_r, oh1_r, oh2_r, tmask_r;
  logic [ADDR_W-1:0]   base_r;
  logic [MAX_TARGETS-1:0] gi_r, oi_r, j_r, last_r;
  logic [WORD_W-1:0]   g_r [MAT_DIM];
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic [ADDR_W-1:0]   gidx, widx;
  logic [ADDR_W:0]     nb;
  logic                nb_done;
  logic                apply_ok, amp_ok, mat_ok;

  // measure
  logic [ADDR_W-1:0]   mi_r;
  logic [PRODW-1:0]    sq_r;
  logic [CUM_W-1:0]    cum_r, cum_nxt, thr;

  // clear
  logic [ADDR_W-1:0]   clr_r;

  // memories
  logic [WORD_W-1:0]   store_mem [STORE_DEPTH];
  logic [WORD_W-1:0]   st_q;
  logic                st_we;
  logic [ADDR_W-1:0]   st_waddr, st_raddr;
  logic [WORD_W-1:0]   st_wdata;

  logic [WORD_W-1:0]   mat_mem [MAT_DEPTH];
  logic [MAT_DEPTH-1:0] mat_vld_r;
  logic [WORD_W-1:0]   mx_q;
  logic                mx_vq;
  logic                mx_we;
  logic [MAT_AW-1:0]   mx_waddr, mx_raddr;
  logic [WORD_W-1:0]   mx_mat;

  // shared multiplier
  cop_t  op_a, op_b;
  prod_t prod;

  // result
  logic [AMP_WIDTH-1:0] res_re_r, res_im_r;
  logic [ADDR_W-1:0]    res_meas_r;
  logic                 res_status_r;
  logic                 out_valid_r;
  logic [AMP_WIDTH-1:0] out_re_r, out_im_r;
  logic [ADDR_W-1:0]    out_meas_r;
  logic                 out_status_r;
  logic                 out_load;

  assign cfg_ch.ready = 1'b1;
  assign n_eff = (qc_r == '0) ? QC_W'(1) :
                 (qc_r > QC_W'(MAX_QUBITS)) ? QC_W'(MAX_QUBITS) : qc_r;
  assign size  = (ADDR_W + 1)'(1) << n_eff;

  assign amp_ok = ({1'b0, pos_r} < size);
  assign mat_ok = (pos_r < 10'(MAT_DIM)) && ({1'b0, col_r} < 4'(MAT_DIM));
  assign apply_ok = (k_r != 2'd0) && ({1'b0, k_r} <= 3'(MAX_TARGETS)) &&
                    (t0_r < n_eff) &&
                    ((k_r < 2'd2) || ((t1_r < n_eff) && (t1_r != t0_r))) &&
                    ((k_r < 2'd3) || ((t2_r < n_eff) && (t2_r != t0_r) &&
                                      (t2_r != t1_r)));

  assign gidx = base_r | (gi_r[0] ? oh0_r : '0) | (gi_r[1] ? oh1_r : '0) |
                (gi_r[2] ? oh2_r : '0);
  assign widx = base_r | (oi_r[0] ? oh0_r : '0) | (oi_r[1] ? oh1_r : '0) |
                (oi_r[2] ? oh2_r : '0);

  // next spectator pattern: carry through the target bits
  assign nb      = ({1'b0, base_r} | {1'b0, tmask_r}) + (ADDR_W + 1)'(1);
  assign nb_done = (nb == size);

  assign thr     = CUM_W'({rand_r, 12'b0});
  assign cum_nxt = cum_r + CUM_W'(sq_r);

  assign mx_mat = mx_vq ? mx_q : '0;

  qsv_cmul u_cmul (.a(op_a), .b(op_b), .p(prod));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_r == '1) state_nxt = init_pend_r ? ST_DONE : ST_IDLE;
      ST_IDLE:    if (in_ch.valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (func_r)
          FN_INIT:    state_nxt = ST_CLEAR;
          FN_APPLY:   state_nxt = apply_ok ? ST_G_RD : ST_DONE;
          FN_RD_AMP:  state_nxt = amp_ok ? ST_RD_WAIT : ST_DONE;
          FN_MEASURE: state_nxt = ST_M_RD;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_RD_WAIT: state_nxt = ST_DONE;
      ST_G_RD:    state_nxt = ST_G_CAP;
      ST_G_CAP:   state_nxt = (gi_r == last_r) ? ST_X_RD : ST_G_RD;
      ST_X_RD:    state_nxt = ST_X_ACC;
      ST_X_ACC:   state_nxt = (j_r == last_r) ? ST_WB : ST_X_RD;
      ST_WB: begin
        if (oi_r != last_r) state_nxt = ST_X_RD;
        else if (nb_done)   state_nxt = ST_DONE;
        else                state_nxt = ST_G_RD;
      end
      ST_M_RD:    state_nxt = ST_M_SQ;
      ST_M_SQ:    state_nxt = ST_M_ACC;
      ST_M_ACC: begin
        if ((thr <= cum_nxt) || ({1'b0, mi_r} == size - (ADDR_W + 1)'(1)))
          state_nxt = ST_DONE;
        else
          state_nxt = ST_M_RD;
      end
      ST_DONE:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    st_we    = 1'b0;
    st_waddr = widx;
    st_wdata = {rnd_sat(acc_re_r), rnd_sat(acc_im_r)};
    st_raddr = gidx;
    mx_we    = 1'b0;
    mx_waddr = {pos_r[MAX_TARGETS-1:0], col_r};
    mx_raddr = {j_r, oi_r};
    out_load = 1'b0;
    op_a = '{re: OPW'($signed(g_r[j_r][WORD_W-1:AMP_WIDTH])),
             im: OPW'($signed(g_r[j_r][AMP_WIDTH-1:0]))};
    op_b = '{re: OPW'($signed(mx_mat[WORD_W-1:AMP_WIDTH])),
             im: OPW'($signed(mx_mat[AMP_WIDTH-1:0]))};
    case (state_r)
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = {(clr_r == '0) ? ONE : AMP_WIDTH'(0), {AMP_WIDTH{1'b0}}};
      end
      ST_EXEC: begin
        st_raddr = pos_r;
        if (func_r == FN_WR_AMP && amp_ok) begin
          st_we    = 1'b1;
          st_waddr = pos_r;
          st_wdata = val_r;
        end
        if (func_r == FN_WR_MAT && mat_ok) mx_we = 1'b1;
      end
      ST_WB:   st_we = 1'b1;
      ST_M_RD: st_raddr = mi_r;
      ST_M_SQ: begin
        // |a|^2 as a * conj(a)
        op_a = '{re: OPW'($signed(st_q[WORD_W-1:AMP_WIDTH])),
                 im: OPW'($signed(st_q[AMP_WIDTH-1:0]))};
        op_b = '{re: OPW'($signed(st_q[WORD_W-1:AMP_WIDTH])),
                 im: -OPW'($signed(st_q[AMP_WIDTH-1:0]))};
      end
      ST_DONE: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (mx_we) mat_mem[mx_waddr] <= val_r;
    mx_q  <= mat_mem[mx_raddr];
    mx_vq <= mat_vld_r[mx_raddr];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      qc_r        <= QC_RESET;
      clr_r       <= '0;
      init_pend_r <= 1'b0;
      mat_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) qc_r <= cfg_ch.data;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
        if (clr_r == '1) init_pend_r <= 1'b0;
      end
      if (state_r == ST_EXEC && func_r == FN_INIT) begin
        clr_r       <= '0;
        init_pend_r <= 1'b1;
      end
      if (mx_we) mat_vld_r[mx_waddr] <= 1'b1;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      pos_r  <= in_ch.position;
      col_r  <= in_ch.column;
      val_r  <= {in_ch.value_re, in_ch.value_im};
      k_r    <= in_ch.target_count;
      t0_r   <= in_ch.target_first;
      t1_r   <= in_ch.target_second;
      t2_r   <= in_ch.target_third;
      rand_r <= in_ch.rand_value;
    end
    case (state_r)
      ST_EXEC: begin
        res_re_r     <= '0;
        res_im_r     <= '0;
        res_meas_r   <= '0;
        case (func_r)
          FN_INIT, FN_MEASURE:  res_status_r <= 1'b0;
          FN_WR_AMP, FN_RD_AMP: res_status_r <= !amp_ok;
          FN_WR_MAT:            res_status_r <= !mat_ok;
          FN_APPLY:             res_status_r <= !apply_ok;
          default:              res_status_r <= 1'b1;
        endcase
        oh0_r   <= ADDR_W'(1) << t0_r;
        oh1_r   <= (k_r >= 2'd2) ? (ADDR_W'(1) << t1_r) : '0;
        oh2_r   <= (k_r >= 2'd3) ? (ADDR_W'(1) << t2_r) : '0;
        tmask_r <= (ADDR_W'(1) << t0_r) |
                   ((k_r >= 2'd2) ? (ADDR_W'(1) << t1_r) : '0) |
                   ((k_r >= 2'd3) ? (ADDR_W'(1) << t2_r) : '0);
        last_r  <= MAX_TARGETS'((1 << k_r) - 1);
        base_r  <= '0;
        gi_r    <= '0;
        oi_r    <= '0;
        j_r     <= '0;
        acc_re_r <= '0;
        acc_im_r <= '0;
        mi_r    <= '0;
        cum_r   <= '0;
      end
      ST_RD_WAIT: begin
        res_re_r <= st_q[WORD_W-1:AMP_WIDTH];
        res_im_r <= st_q[AMP_WIDTH-1:0];
      end
      ST_G_CAP: begin
        g_r[gi_r] <= st_q;
        gi_r      <= gi_r + MAX_TARGETS'(1);
        oi_r      <= '0;
        j_r       <= '0;
      end
      ST_X_ACC: begin
        acc_re_r <= acc_re_r + ACC_W'(prod.re);
        acc_im_r <= acc_im_r + ACC_W'(prod.im);
        j_r      <= j_r + MAX_TARGETS'(1);
      end
      ST_WB: begin
        acc_re_r <= '0;
        acc_im_r <= '0;
        j_r      <= '0;
        oi_r     <= oi_r + MAX_TARGETS'(1);
        if (oi_r == last_r) begin
          base_r <= nb[ADDR_W-1:0] & ~tmask_r;
          gi_r   <= '0;
        end
      end
      ST_M_SQ: sq_r <= prod.re;
      ST_M_ACC: begin
        cum_r <= cum_nxt;
        mi_r  <= mi_r + ADDR_W'(1);
        if (thr <= cum_nxt) res_meas_r <= mi_r;
      end
      default: ;
    endcase
    if (out_load) begin
      out_re_r     <= res_re_r;
      out_im_r     <= res_im_r;
      out_meas_r   <= res_meas_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.amp_re    = out_re_r;
  assign out_ch.amp_im    = out_im_r;
  assign out_ch.basis_idx = out_meas_r;
  assign out_ch.status    = out_status_r;

endmodule

// ----- rtl/qsv_checker.sv -----
// ----------------------------------------------------------------------------
// qsv_checker: port-level checks of the state vector gate engine
// Result hold, one item at a time, clean rejects and the clearing pass.
// ----------------------------------------------------------------------------
module qsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_amp_re,
  input logic [15:0] out_amp_im,
  input logic [9:0]  out_basis_idx,
  input logic        out_status
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_amp_re) &&
    $stable(out_amp_im) && $stable(out_basis_idx) && $stable(out_status))
    else $error("result changed while stalled");

  // one item in flight: ready drops after each accepted transaction
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_amp_re == 16'd0 && out_amp_im == 16'd0 &&
    out_basis_idx == 10'd0)
    else $error("rejected result carries data");

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready during clearing pass");

endmodule

bind qubit_state_vector_gate_engine qsv_checker u_qsv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_amp_re    (out_ch.amp_re),
  .out_amp_im    (out_ch.amp_im),
  .out_basis_idx (out_ch.basis_idx),
  .out_status    (out_ch.status)
);
